FILE: sv/playfair_pkg.sv
// ----------------------------------------------------------------------------
// playfair_pkg
// Shared types, constants and symbol conversion functions for the Playfair
// cipher block on a rectangular square over a 30-symbol alphabet.
// ----------------------------------------------------------------------------
package playfair_pkg;

	// Alphabet: A to Z, then period, comma, question mark and semicolon.
	localparam int unsigned NSYM  = 30;
	localparam int unsigned SYM_W = 5;

	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_Z      = 8'h5A;
	localparam logic [7:0] CH_PERIOD = 8'h2E;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_QUEST  = 8'h3F;
	localparam logic [7:0] CH_SEMI   = 8'h3B;

	localparam logic [SYM_W-1:0] SYM_PERIOD = 5'd26;
	localparam logic [SYM_W-1:0] SYM_COMMA  = 5'd27;
	localparam logic [SYM_W-1:0] SYM_QUEST  = 5'd28;
	localparam logic [SYM_W-1:0] SYM_SEMI   = 5'd29;
	localparam logic [SYM_W-1:0] SYM_LAST   = 5'd29;

	// Opcodes of an input transaction.
	localparam logic [1:0] OP_KEY     = 2'd0;
	localparam logic [1:0] OP_KEY_END = 2'd1;
	localparam logic [1:0] OP_PAIR    = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_SYM = 2'd1;
	localparam logic [1:0] ST_SEQ = 2'd2;

	typedef logic [SYM_W-1:0] sym_code_t;
	typedef logic [NSYM-1:0]  sym_set_t;

	// Decoded character: a valid flag and the symbol code.
	typedef struct packed {
		logic      ok;
		sym_code_t code;
	} sym_t;

	// Commands from the sequencer to the key store.
	typedef struct packed {
		logic place;   // append the symbol to the square if new and room is left
		logic pos_rd;  // read the cell position of the symbol
		logic sq_rd;   // read the symbol held in a cell
	} store_cmd_t;

	// Map an ASCII character to its symbol code.
	function automatic sym_t sym_decode(input logic [7:0] ch);
		sym_t r;
		r.ok   = 1'b1;
		r.code = '0;
		if (ch >= CH_A && ch <= CH_Z) begin
			r.code = SYM_W'(ch - CH_A);
		end else begin
			case (ch)
				CH_PERIOD: r.code = SYM_PERIOD;
				CH_COMMA:  r.code = SYM_COMMA;
				CH_QUEST:  r.code = SYM_QUEST;
				CH_SEMI:   r.code = SYM_SEMI;
				default:   r.ok   = 1'b0;
			endcase
		end
		return r;
	endfunction

	// Map a symbol code back to its ASCII character.
	function automatic logic [7:0] sym_ascii(input sym_code_t s);
		logic [7:0] ch;
		ch = 8'h00;
		case (s)
			SYM_PERIOD: ch = CH_PERIOD;
			SYM_COMMA:  ch = CH_COMMA;
			SYM_QUEST:  ch = CH_QUEST;
			SYM_SEMI:   ch = CH_SEMI;
			default: begin
				if (s < SYM_PERIOD) begin
					ch = CH_A + {3'b000, s};
				end
			end
		endcase
		return ch;
	endfunction

endpackage

FILE: sv/playfair_6x5_cipher.sv
// ----------------------------------------------------------------------------
// playfair_6x5_cipher
// Playfair cipher on a ROWS x COLS square over a 30-symbol alphabet. Key
// symbols build the square, a key-end transaction fills it, and pair
// transactions are then encrypted or decrypted by the direction register.
//
// Channel   Signals                         Handshake
// input     opcode, char_a, char_b          start while busy is low
// result    out_a, out_b, status            done high for one cycle
// config    cfg_wdata                       cfg_we
//
// A key symbol and every failed transaction leave busy low: done rises on
// the cycle after start. A pair makes two position reads and two square
// reads on memories with one read port each, through the shared coordinate
// unit. A key end offers each symbol of the alphabet to the square in turn.
// Reset clears the square, the key and the direction; no clearing pass.
// The receiver cannot stall; a new transaction may start while done is high.
// ----------------------------------------------------------------------------
module playfair_6x5_cipher #(
	parameter int unsigned ROWS = 6,
	parameter int unsigned COLS = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] opcode,
	input  logic [7:0] char_a,
	input  logic [7:0] char_b,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	output logic       done,
	output logic [7:0] out_a,
	output logic [7:0] out_b,
	output logic [1:0] status
);

	import playfair_pkg::*;

	localparam int unsigned RW = $clog2(ROWS);
	localparam int unsigned CW = $clog2(COLS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FILL,
		S_POS_B,
		S_CELL_A,
		S_CELL_B,
		S_FINISH
	} state_t;

	state_t          state_q, state_d;
	sym_code_t       fill_cnt_q;
	sym_code_t       sym_b_q;
	logic [RW-1:0]   r1_q;
	logic [CW-1:0]   c1_q;
	logic            key_complete_q;
	logic            direction_q;
	logic            done_q;
	logic [7:0]      out_a_q;
	logic [7:0]      out_b_q;
	logic [1:0]      status_q;
	logic [7:0]      ascii_a_q;

	sym_t            sa, sb;
	logic            accept;
	logic            fin;
	logic [1:0]      fin_st;
	logic            fill_last;
	store_cmd_t      cmd;
	sym_code_t       st_sym;
	sym_set_t        placed;
	logic [RW-1:0]   pos_r, own_r, oth_r, tgt_r;
	logic [CW-1:0]   pos_c, own_c, oth_c, tgt_c;
	sym_code_t       cell_sym;

	assign accept    = start && (state_q == S_IDLE);
	assign sa        = sym_decode(char_a);
	assign sb        = sym_decode(char_b);
	assign fill_last = (fill_cnt_q == SYM_LAST);

	// Sequencer decisions and store commands for the current cycle.
	always_comb begin
		state_d = state_q;
		fin     = 1'b0;
		fin_st  = ST_OK;
		cmd     = '0;
		st_sym  = sa.code;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (opcode)
						OP_KEY: begin
							fin = 1'b1;
							if (key_complete_q) begin
								fin_st = ST_SEQ;
							end else if (!sa.ok) begin
								fin_st = ST_SYM;
							end else begin
								cmd.place = 1'b1;
							end
						end
						OP_KEY_END: begin
							if (key_complete_q) begin
								fin    = 1'b1;
								fin_st = ST_SEQ;
							end else begin
								state_d = S_FILL;
							end
						end
						OP_PAIR: begin
							if (!key_complete_q) begin
								fin    = 1'b1;
								fin_st = ST_SEQ;
							end else if (!sa.ok || !sb.ok ||
							             !placed[sa.code] || !placed[sb.code]) begin
								fin    = 1'b1;
								fin_st = ST_SYM;
							end else begin
								cmd.pos_rd = 1'b1;
								state_d    = S_POS_B;
							end
						end
						default: begin
							fin    = 1'b1;
							fin_st = ST_SEQ;
						end
					endcase
				end
			end
			S_FILL: begin
				st_sym    = fill_cnt_q;
				cmd.place = 1'b1;
				if (fill_last) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_POS_B: begin
				st_sym     = sym_b_q;
				cmd.pos_rd = 1'b1;
				state_d    = S_CELL_A;
			end
			S_CELL_A: begin
				cmd.sq_rd = 1'b1;
				state_d   = S_CELL_B;
			end
			S_CELL_B: begin
				cmd.sq_rd = 1'b1;
				state_d   = S_FINISH;
			end
			S_FINISH: begin
				fin     = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// The coordinate unit serves the first symbol, then the second.
	always_comb begin
		if (state_q == S_CELL_B) begin
			own_r = pos_r;
			own_c = pos_c;
			oth_r = r1_q;
			oth_c = c1_q;
		end else begin
			own_r = r1_q;
			own_c = c1_q;
			oth_r = pos_r;
			oth_c = pos_c;
		end
	end

	playfair_move #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_move (
		.dir   (direction_q),
		.own_r (own_r),
		.own_c (own_c),
		.oth_r (oth_r),
		.oth_c (oth_c),
		.tgt_r (tgt_r),
		.tgt_c (tgt_c)
	);

	playfair_store #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sym      (st_sym),
		.cell_r   (tgt_r),
		.cell_c   (tgt_c),
		.placed   (placed),
		.pos_r    (pos_r),
		.pos_c    (pos_c),
		.cell_sym (cell_sym)
	);

	// State, item registers and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			fill_cnt_q     <= '0;
			sym_b_q        <= '0;
			r1_q           <= '0;
			c1_q           <= '0;
			key_complete_q <= 1'b0;
			direction_q    <= 1'b0;
			done_q         <= 1'b0;
			out_a_q        <= '0;
			out_b_q        <= '0;
			status_q       <= ST_OK;
			ascii_a_q      <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (cfg_we) begin
				direction_q <= cfg_wdata;
			end
			if (accept) begin
				sym_b_q    <= sb.code;
				fill_cnt_q <= '0;
			end
			if (state_q == S_FILL) begin
				fill_cnt_q <= fill_cnt_q + SYM_W'(1);
				if (fill_last) begin
					key_complete_q <= 1'b1;
				end
			end
			if (state_q == S_POS_B) begin
				r1_q <= pos_r;
				c1_q <= pos_c;
			end
			if (state_q == S_CELL_B) begin
				ascii_a_q <= sym_ascii(cell_sym);
			end
			if (fin) begin
				status_q <= fin_st;
				if (state_q == S_FINISH) begin
					out_a_q <= ascii_a_q;
					out_b_q <= sym_ascii(cell_sym);
				end else begin
					out_a_q <= '0;
					out_b_q <= '0;
				end
			end
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign out_a  = out_a_q;
	assign out_b  = out_b_q;
	assign status = status_q;

endmodule

FILE: sv/playfair_move.sv
// ----------------------------------------------------------------------------
// playfair_move
// Shared coordinate unit. Given the cell of one symbol of a pair and the
// cell of the other, it gives the cell of the transformed symbol.
// ----------------------------------------------------------------------------
module playfair_move #(
	parameter int unsigned ROWS = 6,
	parameter int unsigned COLS = 5
) (
	input  logic                      dir,
	input  logic [$clog2(ROWS)-1:0]   own_r,
	input  logic [$clog2(COLS)-1:0]   own_c,
	input  logic [$clog2(ROWS)-1:0]   oth_r,
	input  logic [$clog2(COLS)-1:0]   oth_c,
	output logic [$clog2(ROWS)-1:0]   tgt_r,
	output logic [$clog2(COLS)-1:0]   tgt_c
);

	localparam int unsigned RW = $clog2(ROWS);
	localparam int unsigned CW = $clog2(COLS);
	localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
	localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);

	logic [RW-1:0] r_next;
	logic [CW-1:0] c_next;

	// Step one place with wraparound: forward to encrypt, backward to decrypt.
	always_comb begin
		if (dir) begin
			r_next = (own_r == '0) ? ROW_LAST : own_r - RW'(1);
			c_next = (own_c == '0) ? COL_LAST : own_c - CW'(1);
		end else begin
			r_next = (own_r == ROW_LAST) ? '0 : own_r + RW'(1);
			c_next = (own_c == COL_LAST) ? '0 : own_c + CW'(1);
		end
	end

	// Same row shifts the column, same column shifts the row, otherwise the
	// symbol takes the column of the other corner.
	always_comb begin
		if (own_r == oth_r) begin
			tgt_r = own_r;
			tgt_c = c_next;
		end else if (own_c == oth_c) begin
			tgt_r = r_next;
			tgt_c = own_c;
		end else begin
			tgt_r = own_r;
			tgt_c = oth_c;
		end
	end

endmodule

FILE: sv/playfair_store.sv
// ----------------------------------------------------------------------------
// playfair_store
// Key square store: the square memory, the symbol position memory, the
// placed flags and the fill pointer. Cells past the fill pointer read as the
// first symbol of the alphabet.
// ----------------------------------------------------------------------------
module playfair_store #(
	parameter int unsigned ROWS = 6,
	parameter int unsigned COLS = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  playfair_pkg::store_cmd_t       cmd,
	input  playfair_pkg::sym_code_t        sym,
	input  logic [$clog2(ROWS)-1:0]        cell_r,
	input  logic [$clog2(COLS)-1:0]        cell_c,
	output playfair_pkg::sym_set_t         placed,
	output logic [$clog2(ROWS)-1:0]        pos_r,
	output logic [$clog2(COLS)-1:0]        pos_c,
	output playfair_pkg::sym_code_t        cell_sym
);

	import playfair_pkg::*;

	localparam int unsigned RW  = $clog2(ROWS);
	localparam int unsigned CW  = $clog2(COLS);
	localparam int unsigned AW  = RW + CW;
	localparam int unsigned FRW = $clog2(ROWS + 1);
	localparam logic [CW-1:0]  COL_LAST = CW'(COLS - 1);
	localparam logic [FRW-1:0] ROW_END  = FRW'(ROWS);

	sym_code_t         sq_mem [2**AW];
	logic [AW-1:0]     pos_mem [NSYM];

	sym_set_t          placed_q;
	logic [FRW-1:0]    fill_r_q;
	logic [CW-1:0]     fill_c_q;
	sym_code_t         sq_rd_q;
	logic              sq_vld_q;
	logic [AW-1:0]     pos_rd_q;

	logic              full;
	logic              do_place;
	logic [AW-1:0]     wr_addr;
	logic              cell_vld;

	// A symbol is placed only when it is new and the square has room.
	assign full     = (fill_r_q == ROW_END);
	assign do_place = cmd.place && !full && !placed_q[sym];
	assign wr_addr  = {fill_r_q[RW-1:0], fill_c_q};

	// Cells are filled in row order, so a cell holds a symbol only if it lies
	// before the fill pointer.
	assign cell_vld = (FRW'(cell_r) < fill_r_q) ||
	                  ((FRW'(cell_r) == fill_r_q) && (cell_c < fill_c_q));

	// Memories: one write port each, registered reads.
	always_ff @(posedge clk) begin
		if (do_place) begin
			sq_mem[wr_addr] <= sym;
			pos_mem[sym]    <= wr_addr;
		end
		if (cmd.sq_rd) begin
			sq_rd_q <= sq_mem[{cell_r, cell_c}];
		end
		if (cmd.pos_rd) begin
			pos_rd_q <= pos_mem[sym];
		end
	end

	// Placed flags, fill pointer and read valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			placed_q <= '0;
			fill_r_q <= '0;
			fill_c_q <= '0;
			sq_vld_q <= 1'b0;
		end else begin
			if (do_place) begin
				placed_q[sym] <= 1'b1;
				if (fill_c_q == COL_LAST) begin
					fill_c_q <= '0;
					fill_r_q <= fill_r_q + FRW'(1);
				end else begin
					fill_c_q <= fill_c_q + CW'(1);
				end
			end
			if (cmd.sq_rd) begin
				sq_vld_q <= cell_vld;
			end
		end
	end

	assign placed   = placed_q;
	assign pos_r    = pos_rd_q[AW-1:CW];
	assign pos_c    = pos_rd_q[CW-1:0];
	assign cell_sym = sq_vld_q ? sq_rd_q : '0;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the 6x5 Playfair cipher. An initial block
// builds one key square, then queues cipher pairs in phases with both
// directions. A clocked driver feeds the transactions with random gaps. A
// clocked monitor compares every result with a local predictor of the square,
// the key sequencing and the row, column and rectangle rules.
// ----------------------------------------------------------------------------
module tb_top;
	import playfair_pkg::*;

	localparam int ROWS  = 6;
	localparam int COLS  = 5;
	localparam int CELLS = ROWS * COLS;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int REPORT_LIMIT   = 10;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// Symbol code i is the character at position i of this string.
	localparam string SYMBOL_SET = "ABCDEFGHIJKLMNOPQRSTUVWXYZ.,?;";

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] first;
		logic [7:0] second;
	} cipher_cmd_t;

	typedef struct packed {
		logic [7:0] first;
		logic [7:0] second;
		logic [1:0] st;
	} cipher_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic [1:0] opcode = OP_KEY;
	logic [7:0] char_a = 8'h00;
	logic [7:0] char_b = 8'h00;
	logic       cfg_we = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       done;
	logic [7:0] out_a;
	logic [7:0] out_b;
	logic [1:0] status;

	// Transactions waiting to be driven and results waiting to be seen.
	cipher_cmd_t    queued_cmds[$];
	cipher_result_t predicted_results[$];

	int n_issued = 0;
	int n_accepted = 0;
	int gap_left = 0;
	int gap_rate = 0;
	int fail_count = 0;
	int n_results = 0;
	int idle_cycles = 0;

	// Predictor state: the key square and its bookkeeping.
	sym_code_t   key_square[CELLS];
	logic [4:0]  cell_of[NSYM];
	sym_set_t    key_placed = '0;
	logic [4:0]  key_fill = '0;
	logic        key_done = 1'b0;
	logic        cipher_dir = 1'b0;

	int n_row = 0, n_col = 0, n_rect = 0, n_decrypt = 0;
	int n_rej_sym = 0, n_rej_seq = 0;

	playfair_6x5_cipher dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.opcode   (opcode),
		.char_a   (char_a),
		.char_b   (char_b),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.done     (done),
		.out_a    (out_a),
		.out_b    (out_b),
		.status   (status)
	);

	always #2 clk = ~clk;

	// Symbol code of a character, or -1 when it is outside the alphabet.
	function automatic int char_to_symbol(input logic [7:0] ch);
		int i;
		for (i = 0; i < NSYM; i++) begin
			if (SYMBOL_SET[i] == ch) return i;
		end
		return -1;
	endfunction

	// Append a symbol to the square unless it is already placed or the square is full.
	function automatic void key_append(input int s);
		if (key_fill >= CELLS || key_placed[s]) return;
		key_square[key_fill] = sym_code_t'(s);
		cell_of[s] = key_fill;
		key_placed[s] = 1'b1;
		key_fill++;
	endfunction

	function automatic logic [7:0] square_char(input int r, input int c);
		return SYMBOL_SET[key_square[(r % ROWS) * COLS + (c % COLS)]];
	endfunction

	// Expected result of one transaction; updates the key state as the block does.
	function automatic cipher_result_t playfair_predict(input cipher_cmd_t cmd);
		cipher_result_t res;
		int s1, s2, r1, c1, r2, c2, dr, dc, s;
		res = '0;
		res.st = ST_OK;
		s1 = char_to_symbol(cmd.first);
		s2 = char_to_symbol(cmd.second);
		case (cmd.op)
			OP_KEY: begin
				if (key_done) res.st = ST_SEQ;
				else if (s1 < 0) res.st = ST_SYM;
				else key_append(s1);
			end
			OP_KEY_END: begin
				if (key_done) begin
					res.st = ST_SEQ;
				end else begin
					for (s = 0; s < NSYM; s++) key_append(s);
					key_done = 1'b1;
				end
			end
			OP_PAIR: begin
				if (!key_done) begin
					res.st = ST_SEQ;
				end else if (s1 < 0 || s2 < 0 || !key_placed[s1] || !key_placed[s2]) begin
					res.st = ST_SYM;
				end else begin
					r1 = int'(cell_of[s1]) / COLS;
					c1 = int'(cell_of[s1]) % COLS;
					r2 = int'(cell_of[s2]) / COLS;
					c2 = int'(cell_of[s2]) % COLS;
					dc = cipher_dir ? COLS - 1 : 1;
					dr = cipher_dir ? ROWS - 1 : 1;
					if (cipher_dir) n_decrypt++;
					if (r1 == r2) begin
						res.first  = square_char(r1, c1 + dc);
						res.second = square_char(r2, c2 + dc);
						n_row++;
					end else if (c1 == c2) begin
						res.first  = square_char(r1 + dr, c1);
						res.second = square_char(r2 + dr, c2);
						n_col++;
					end else begin
						res.first  = square_char(r1, c2);
						res.second = square_char(r2, c1);
						n_rect++;
					end
				end
			end
			default: res.st = ST_SEQ;
		endcase
		if (res.st == ST_SYM) n_rej_sym++;
		if (res.st == ST_SEQ) n_rej_seq++;
		return res;
	endfunction

	task automatic queue_cmd(input logic [1:0] op, input logic [7:0] a, input logic [7:0] b);
		cipher_cmd_t cmd;
		cmd.op = op;
		cmd.first = a;
		cmd.second = b;
		queued_cmds.push_back(cmd);
	endtask

	// Wait until every queued transaction is taken and every result has come back.
	task automatic drain();
		while (queued_cmds.size() != 0 || start || n_accepted != n_issued ||
				predicted_results.size() != 0 || busy) begin
			@(negedge clk);
		end
	endtask

	task automatic write_direction(input logic dir);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= dir;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Driver: presents one transaction at a time, with random gaps between them.
	always @(negedge clk) begin : cmd_driver
		cipher_cmd_t cmd;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && n_accepted != n_issued) begin
			// The block has not taken the transaction yet, so it stays put.
		end else if (gap_left > 0) begin
			gap_left--;
			start <= 1'b0;
		end else if (queued_cmds.size() != 0 && $urandom_range(0, 99) < gap_rate) begin
			gap_left = $urandom_range(1, 15) - 1;
			start <= 1'b0;
		end else if (queued_cmds.size() != 0) begin
			cmd = queued_cmds.pop_front();
			start  <= 1'b1;
			opcode <= cmd.op;
			char_a <= cmd.first;
			char_b <= cmd.second;
			n_issued++;
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor: checks results first, since a result never belongs to a
	// transaction taken at the same edge, then predicts newly taken ones.
	always @(posedge clk) begin : result_check
		cipher_result_t got, want;
		if (arst_n) begin
			if (done) begin
				got.first = out_a;
				got.second = out_b;
				got.st = status;
				n_results++;
				if (predicted_results.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("%0t: unexpected result out_a=%h out_b=%h status=%0d",
							$time, out_a, out_b, status);
				end else begin
					want = predicted_results.pop_front();
					if (got != want) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display({"%0t: mismatch out_a exp %h got %h, ",
								"out_b exp %h got %h, status exp %0d got %0d"},
								$time, want.first, got.first, want.second, got.second,
								want.st, got.st);
					end
				end
			end
			if (cfg_we) cipher_dir = cfg_wdata;
			if (start && !busy) begin
				predicted_results.push_back(playfair_predict({opcode, char_a, char_b}));
				n_accepted++;
			end
		end
	end

	// Watchdog: ends the run when neither a transaction nor a result moves for too long.
	always @(posedge clk) begin : watchdog
		if (!arst_n || (start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin : stimulus
		int key_order[NSYM];
		int n_key, i, j, tmp, r, c1, c2, r2, kind, phase;
		bit full_key;
		logic dir;
		logic [7:0] ca, cb;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		write_direction(1'b0);
		gap_rate = 10;

		// Sequencing errors and unknown characters before any key symbol.
		queue_cmd(OP_UNUSED, 8'hFF, 8'hFF);
		queue_cmd(OP_PAIR, "A", "B");
		queue_cmd(OP_KEY, 8'h00, 8'h00);
		queue_cmd(OP_KEY, 8'hFF, 8'hFF);
		queue_cmd(OP_KEY, "a", "A");
		queue_cmd(OP_KEY, "@", 8'h00);
		queue_cmd(OP_KEY, "[", 8'h00);

		// The key: sometimes every symbol so the square fills before key end,
		// otherwise a short key with repeats that key end completes.
		full_key = ($urandom_range(0, 3) == 0);
		if (full_key) begin
			for (i = 0; i < NSYM; i++) key_order[i] = i;
			for (i = NSYM - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				tmp = key_order[i];
				key_order[i] = key_order[j];
				key_order[j] = tmp;
			end
			for (i = 0; i < NSYM; i++) begin
				queue_cmd(OP_KEY, SYMBOL_SET[key_order[i]], 8'($urandom_range(0, 255)));
				if ($urandom_range(0, 4) == 0)
					queue_cmd(OP_KEY, SYMBOL_SET[key_order[$urandom_range(0, i)]], 8'h00);
			end
			// Square is full: this one is dropped.
			queue_cmd(OP_KEY, SYMBOL_SET[$urandom_range(0, NSYM - 1)], 8'h00);
		end else begin
			n_key = $urandom_range(0, 20);
			for (i = 0; i < n_key; i++)
				queue_cmd(OP_KEY, SYMBOL_SET[$urandom_range(0, NSYM - 1)],
					8'($urandom_range(0, 255)));
		end
		queue_cmd(OP_KEY_END, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));

		// Key transactions after completion are out of sequence.
		queue_cmd(OP_KEY, "A", 8'h00);
		queue_cmd(OP_KEY_END, 8'h00, 8'h00);
		queue_cmd(OP_UNUSED, "A", "B");
		drain();

		// Directed pairs: alphabet ends, a doubled symbol, unknown characters
		// and one pair of each geometry taken from the finished square.
		queue_cmd(OP_PAIR, "A", "Z");
		queue_cmd(OP_PAIR, ".", ";");
		queue_cmd(OP_PAIR, ",", "?");
		queue_cmd(OP_PAIR, "Q", "Q");
		queue_cmd(OP_PAIR, "z", "A");
		queue_cmd(OP_PAIR, 8'hFF, "B");
		queue_cmd(OP_PAIR, "C", 8'h00);
		queue_cmd(OP_PAIR, SYMBOL_SET[key_square[0]], SYMBOL_SET[key_square[COLS - 1]]);
		queue_cmd(OP_PAIR, SYMBOL_SET[key_square[CELLS - 1]],
			SYMBOL_SET[key_square[COLS - 1]]);
		queue_cmd(OP_PAIR, SYMBOL_SET[key_square[0]], SYMBOL_SET[key_square[CELLS - 1]]);
		drain();

		// Random phases; the direction is written before each (decrypt, encrypt, then random) and the last has no gaps.
		for (phase = 0; phase < 6; phase++) begin
			if (phase == 0) dir = 1'b1;
			else if (phase == 1) dir = 1'b0;
			else dir = 1'($urandom_range(0, 1));
			write_direction(dir);
			gap_rate = (phase == 5) ? 0 : $urandom_range(3, 25);
			for (i = 0; i < 236; i++) begin
				kind = $urandom_range(0, 19);
				r  = $urandom_range(0, ROWS - 1);
				r2 = $urandom_range(0, ROWS - 1);
				c1 = $urandom_range(0, COLS - 1);
				c2 = $urandom_range(0, COLS - 1);
				ca = SYMBOL_SET[$urandom_range(0, NSYM - 1)];
				cb = SYMBOL_SET[$urandom_range(0, NSYM - 1)];
				if (kind <= 2) begin
					queue_cmd(OP_PAIR, SYMBOL_SET[key_square[r * COLS + c1]],
						SYMBOL_SET[key_square[r * COLS + c2]]);
				end else if (kind <= 5) begin
					queue_cmd(OP_PAIR, SYMBOL_SET[key_square[r * COLS + c1]],
						SYMBOL_SET[key_square[r2 * COLS + c1]]);
				end else if (kind <= 16) begin
					queue_cmd(OP_PAIR, ca, cb);
				end else if (kind == 17) begin
					if ($urandom_range(0, 1))
						queue_cmd(OP_PAIR, 8'($urandom_range(0, 255)), cb);
					else
						queue_cmd(OP_PAIR, ca, 8'($urandom_range(0, 255)));
				end else begin
					queue_cmd(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
				end
			end
			drain();
		end

		// Watch for expected results that never arrived.
		repeat (64) @(posedge clk);
		if (predicted_results.size() != 0) begin
			fail_count += predicted_results.size();
			$display("%0d expected results never arrived", predicted_results.size());
		end

		$display({"Checked %0d results: %0d same-row, %0d same-column, ",
			"%0d rectangle pairs, %0d decrypted."},
			n_results, n_row, n_col, n_rect, n_decrypt);
		$display("Rejected %0d unknown-symbol and %0d out-of-sequence transactions; key %0s.",
			n_rej_sym, n_rej_seq, full_key ? "filled the whole square" : "completed by key end");
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/playfair_pkg.sv
sv/playfair_move.sv
sv/playfair_store.sv
sv/playfair_6x5_cipher.sv
tb/tb_top.sv
